[hdl/bile_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bile_pkg
// Shared constants and types for the bounded indexed list engine: sizes,
// operation codes, the list RAM request and the result record.
// ----------------------------------------------------------------------------
package bile_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int FUNC_W     = 3;

  // operation codes carried in the request
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 3'd0,
    FN_REMOVE  = 3'd1,
    FN_REPLACE = 3'd2,
    FN_SELECT  = 3'd3,
    FN_SEARCH  = 3'd4
  } func_t;

  // one access to the list RAM
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  // one result record
  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] data_out;
    logic [CNT_W-1:0]      found_position;
    logic [CNT_W-1:0]      entry_count;
    logic                  is_empty;
    logic                  is_full;
  } res_t;

endpackage

[hdl/bile_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bile_mem
// List store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module bile_mem (
  input  logic                            clk,
  input  bile_pkg::mem_req_t              req,
  output logic [bile_pkg::DATA_WIDTH-1:0] rdata
);

  logic [bile_pkg::DATA_WIDTH-1:0] mem [bile_pkg::CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[hdl/bile_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bile_seq
// Operation sequencer: holds the entry count, walks the list RAM one entry
// per read/use pair to shift, select or search, and builds the result.
// ----------------------------------------------------------------------------
module bile_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bile_pkg::FUNC_W-1:0]     func,
  input  logic [bile_pkg::CNT_W-1:0]      position,
  input  logic [bile_pkg::DATA_WIDTH-1:0] data_in,
  output bile_pkg::mem_req_t              mem_req,
  input  logic [bile_pkg::DATA_WIDTH-1:0] mem_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output bile_pkg::res_t                  res
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_USE  = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam logic [bile_pkg::CNT_W-1:0] CAP_CNT = bile_pkg::CNT_W'(bile_pkg::CAPACITY);
  localparam logic [bile_pkg::CNT_W-1:0] ONE     = bile_pkg::CNT_W'(1);
  localparam logic [bile_pkg::CNT_W-1:0] TWO     = bile_pkg::CNT_W'(2);

  state_t                          state, state_next;
  logic [bile_pkg::FUNC_W-1:0]     op, op_next;
  logic [bile_pkg::CNT_W-1:0]      pos, pos_next;
  logic [bile_pkg::DATA_WIDTH-1:0] value, value_next;
  logic [bile_pkg::CNT_W-1:0]      idx, idx_next;
  logic [bile_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic                            res_ok, res_ok_next;
  logic [bile_pkg::DATA_WIDTH-1:0] res_dout, res_dout_next;
  logic [bile_pkg::CNT_W-1:0]      res_fpos, res_fpos_next;

  logic [bile_pkg::CNT_W-1:0] idx_dec, idx_inc, idx_inc2;
  logic [bile_pkg::CNT_W:0]   pos_inc;

  assign idx_dec  = idx - ONE;
  assign idx_inc  = idx + ONE;
  assign idx_inc2 = idx + TWO;
  assign pos_inc  = {1'b0, position} + {{bile_pkg::CNT_W{1'b0}}, 1'b1};

  // next state, RAM request and result bookkeeping
  always_comb begin
    state_next    = state;
    op_next       = op;
    pos_next      = pos;
    value_next    = value;
    idx_next      = idx;
    cnt_next      = cnt;
    res_ok_next   = res_ok;
    res_dout_next = res_dout;
    res_fpos_next = res_fpos;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx[bile_pkg::ADDR_W-1:0];
    mem_req.wdata = mem_rdata;
    mem_req.re    = 1'b0;
    mem_req.raddr = idx[bile_pkg::ADDR_W-1:0];
    in_ready      = 1'b0;
    res_valid     = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next       = func;
          pos_next      = position;
          value_next    = data_in;
          res_ok_next   = 1'b0;
          res_dout_next = '0;
          res_fpos_next = '0;
          state_next    = S_DONE;
          unique case (func)
            bile_pkg::FN_INSERT: begin
              if (position <= cnt && cnt < CAP_CNT) begin
                idx_next   = cnt;
                state_next = (cnt > position) ? S_READ : S_PUT;
              end
            end
            bile_pkg::FN_REMOVE: begin
              if (position < cnt) begin
                idx_next = position;
                if (pos_inc < {1'b0, cnt}) begin
                  state_next = S_READ;
                end else begin
                  cnt_next    = cnt - ONE;
                  res_ok_next = 1'b1;
                end
              end
            end
            bile_pkg::FN_REPLACE: begin
              if (position < cnt) begin
                state_next = S_PUT;
              end
            end
            bile_pkg::FN_SELECT: begin
              if (position < cnt) begin
                idx_next   = position;
                state_next = S_READ;
              end else if (cnt != '0) begin
                idx_next   = cnt - ONE;
                state_next = S_READ;
              end
            end
            bile_pkg::FN_SEARCH: begin
              res_fpos_next = cnt;
              idx_next      = '0;
              if (cnt != '0) begin
                state_next = S_READ;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // issue the read for the entry this step needs
      S_READ: begin
        mem_req.re = 1'b1;
        case (op)
          bile_pkg::FN_INSERT: mem_req.raddr = idx_dec[bile_pkg::ADDR_W-1:0];
          bile_pkg::FN_REMOVE: mem_req.raddr = idx_inc[bile_pkg::ADDR_W-1:0];
          default:             mem_req.raddr = idx[bile_pkg::ADDR_W-1:0];
        endcase
        state_next = S_USE;
      end

      // consume read data: shift one entry, capture or compare
      S_USE: begin
        unique case (op)
          bile_pkg::FN_INSERT: begin
            mem_req.we = 1'b1;
            idx_next   = idx_dec;
            state_next = (idx_dec > pos) ? S_READ : S_PUT;
          end
          bile_pkg::FN_REMOVE: begin
            mem_req.we = 1'b1;
            idx_next   = idx_inc;
            if (idx_inc2 < cnt) begin
              state_next = S_READ;
            end else begin
              cnt_next    = cnt - ONE;
              res_ok_next = 1'b1;
              state_next  = S_DONE;
            end
          end
          bile_pkg::FN_SELECT: begin
            res_dout_next = mem_rdata;
            res_ok_next   = (pos < cnt);
            state_next    = S_DONE;
          end
          bile_pkg::FN_SEARCH: begin
            if (mem_rdata == value) begin
              res_ok_next   = 1'b1;
              res_fpos_next = idx;
              state_next    = S_DONE;
            end else begin
              idx_next   = idx_inc;
              state_next = (idx_inc < cnt) ? S_READ : S_DONE;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      // write the new value at the requested position
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos[bile_pkg::ADDR_W-1:0];
        mem_req.wdata = value;
        res_ok_next   = 1'b1;
        if (op == bile_pkg::FN_INSERT) begin
          cnt_next = cnt + ONE;
        end
        state_next = S_DONE;
      end

      // hand the result over once the output register is free
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.ok             = res_ok;
  assign res.data_out       = res_dout;
  assign res.found_position = res_fpos;
  assign res.entry_count    = cnt;
  assign res.is_empty       = (cnt == '0);
  assign res.is_full        = (cnt == CAP_CNT);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    op       <= op_next;
    pos      <= pos_next;
    value    <= value_next;
    idx      <= idx_next;
    res_ok   <= res_ok_next;
    res_dout <= res_dout_next;
    res_fpos <= res_fpos_next;
  end

endmodule

[hdl/bounded_indexed_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_indexed_list_engine
// Ordered list of up to 64 words with insert, remove, replace, select and
// search at a list position; every result reports count, empty and full.
// ----------------------------------------------------------------------------
//  channel   dir  signals                      content
//  request   in   s_tvalid/s_tready/s_tdata    position, data_in
//                 s_tuser                      func
//  result    out  m_tvalid/m_tready/m_tdata    ok, data_out, found_position,
//                                              entry_count, is_empty, is_full
//
//  One request at a time. Replace runs a put step; select one read/use pair.
//  Insert runs a read/use pair per entry shifted, then a put; remove a
//  read/use pair per entry shifted; search a read/use pair per entry
//  compared. A search over a full list with no match is the worst case from
//  one request to the next, set by the read and use of each entry in the RAM.
//  Reset clears the count, state and output valid; RAM contents stay unknown until written.
//  A stalled result sits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module bounded_indexed_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [6:0] position, [38:7] data_in, [39] zero
  input  logic [2:0]  s_tuser,   // [2:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // [0] ok, [32:1] data_out, [39:33] found_position,
                                 // [46:40] entry_count, [47] is_empty, [48] is_full,
                                 // [55:49] zero
);

  bile_pkg::mem_req_t              mem_req;
  logic [bile_pkg::DATA_WIDTH-1:0] mem_rdata;
  bile_pkg::res_t                  res;
  logic                            res_valid;
  logic                            out_free;

  assign out_free = !m_tvalid || m_tready;

  bile_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (s_tuser),
    .position  (s_tdata[6:0]),
    .data_in   (s_tdata[38:7]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (out_free),
    .res       (res)
  );

  bile_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output beat valid: set on a new result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_tdata <= {7'd0, res.is_full, res.is_empty, res.entry_count,
                  res.found_position, res.data_out, res.ok};
    end
  end

endmodule
